// ===== hw/rtl/dstt_pkg.sv =====
// Shared types, constants and command codes for the delayed start timer table.
package dstt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int CMD_W         = 2;
   localparam int CLIENT_W      = 6;
   localparam int DELAY_W       = 20;
   localparam int TIME_W        = 32;
   localparam int COUNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

   // Broadcast from the controller to every cell while the token walks.
   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [CLIENT_W-1:0] client;
      logic [TIME_W-1:0]   stamp;   // due time for add, current time for tick
      logic                search;  // add or cancel still looking for its slot
      logic                allow;   // tick may still release
   } cell_bus_type;

   // Status gathered from the chain for the controller.
   typedef struct packed {
      logic                hit;
      logic [CLIENT_W-1:0] client;
      logic                tail;    // token sits in the last cell
   } chain_stat_type;

endpackage

// ===== hw/rtl/dstt_cell.sv =====
// One timer slot: valid bit, due time and client, acting when the token passes.
module dstt_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            token_in,
   output logic                            token_out,
   input  dstt_pkg::cell_bus_type          bus,
   output logic                            hit,
   output logic [dstt_pkg::CLIENT_W-1:0]   hit_client
);

   logic                            token_ff;
   logic                            valid_ff, valid_in;
   logic [dstt_pkg::TIME_W-1:0]     due_ff, due_in;
   logic [dstt_pkg::CLIENT_W-1:0]   client_ff, client_in;

   always_comb begin
      hit       = 1'b0;
      valid_in  = valid_ff;
      due_in    = due_ff;
      client_in = client_ff;
      if (token_ff) begin
         case (bus.cmd)
            dstt_pkg::CMD_TICK: begin
               if (valid_ff && (due_ff <= bus.stamp) && bus.allow) begin
                  hit      = 1'b1;
                  valid_in = 1'b0;
               end
            end
            dstt_pkg::CMD_ADD: begin
               if (!valid_ff && bus.search) begin
                  hit       = 1'b1;
                  valid_in  = 1'b1;
                  due_in    = bus.stamp;
                  client_in = bus.client;
               end
            end
            dstt_pkg::CMD_CANCEL: begin
               if (valid_ff && bus.search && (client_ff == bus.client)) begin
                  hit      = 1'b1;
                  valid_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign token_out  = token_ff;
   assign hit_client = client_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         token_ff <= token_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff    <= due_in;
      client_ff <= client_in;
   end

endmodule

// ===== hw/rtl/dstt_ctrl.sv =====
// Command sequencer: latches an item, walks the token, orders and emits results.
module dstt_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dstt_pkg::CMD_W-1:0]      req_cmd,
   input  logic [dstt_pkg::CLIENT_W-1:0]   req_client,
   input  logic [dstt_pkg::DELAY_W-1:0]    req_delay_ms,
   input  logic [dstt_pkg::TIME_W-1:0]     req_now_ms,
   output logic                            inject,
   output dstt_pkg::cell_bus_type          bus,
   input  dstt_pkg::chain_stat_type        stat,
   output logic                            rsp_strobe,
   output logic [dstt_pkg::CLIENT_W-1:0]   rsp_start_client,
   output logic                            rsp_table_full,
   output logic                            rsp_last
);

   dstt_pkg::state_type state_ff, state_in;

   logic [dstt_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [dstt_pkg::CLIENT_W-1:0]   client_ff, client_in;
   logic [dstt_pkg::TIME_W-1:0]     stamp_ff, stamp_in;
   logic                            search_ff, search_in;
   logic [dstt_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                            pend_ff, pend_in;
   logic [dstt_pkg::CLIENT_W-1:0]   pend_client_ff, pend_client_in;
   logic                            strobe_ff, strobe_in;
   logic [dstt_pkg::CLIENT_W-1:0]   out_client_ff, out_client_in;
   logic                            full_ff, full_in;
   logic                            last_ff, last_in;

   logic                            accept;
   logic [dstt_pkg::TIME_W:0]       due_sum;
   logic [dstt_pkg::TIME_W-1:0]     due_sat;

   assign accept  = start && (state_ff == dstt_pkg::ST_IDLE);
   assign due_sum = {1'b0, req_now_ms}
                  + {{(dstt_pkg::TIME_W + 1 - dstt_pkg::DELAY_W){1'b0}}, req_delay_ms};
   assign due_sat = due_sum[dstt_pkg::TIME_W] ? {dstt_pkg::TIME_W{1'b1}}
                                              : due_sum[dstt_pkg::TIME_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dstt_pkg::ST_IDLE:  if (accept) state_in = dstt_pkg::ST_SWEEP;
         dstt_pkg::ST_SWEEP: if (stat.tail) state_in = dstt_pkg::ST_FLUSH;
         dstt_pkg::ST_FLUSH: state_in = dstt_pkg::ST_IDLE;
         default:            state_in = dstt_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath
   always_comb begin
      cmd_in         = cmd_ff;
      client_in      = client_ff;
      stamp_in       = stamp_ff;
      search_in      = search_ff;
      count_in       = count_ff;
      pend_in        = pend_ff;
      pend_client_in = pend_client_ff;
      strobe_in      = 1'b0;
      out_client_in  = pend_client_ff;
      full_in        = 1'b0;
      last_in        = 1'b0;
      unique case (state_ff)
         dstt_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_cmd;
               client_in = req_client;
               stamp_in  = (req_cmd == dstt_pkg::CMD_ADD) ? due_sat : req_now_ms;
               search_in = 1'b1;
               count_in  = '0;
               pend_in   = 1'b0;
            end
         end
         dstt_pkg::ST_SWEEP: begin
            if (stat.hit) begin
               if (cmd_ff == dstt_pkg::CMD_TICK) begin
                  // hold the new release until we know whether another follows
                  strobe_in      = pend_ff;
                  pend_in        = 1'b1;
                  pend_client_in = stat.client;
                  count_in       = count_ff + 1'b1;
               end else begin
                  search_in = 1'b0;
               end
            end
         end
         dstt_pkg::ST_FLUSH: begin
            if (cmd_ff == dstt_pkg::CMD_TICK) begin
               strobe_in = pend_ff;
               last_in   = 1'b1;
               pend_in   = 1'b0;
            end else if ((cmd_ff == dstt_pkg::CMD_ADD) && search_ff) begin
               strobe_in     = 1'b1;
               out_client_in = client_ff;
               full_in       = 1'b1;
               last_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign busy       = (state_ff != dstt_pkg::ST_IDLE);
   assign inject     = accept;
   assign bus.cmd    = cmd_ff;
   assign bus.client = client_ff;
   assign bus.stamp  = stamp_ff;
   assign bus.search = search_ff;
   assign bus.allow  = (count_ff < dstt_pkg::COUNT_W'(dstt_pkg::MAX_RESULTS));

   assign rsp_strobe       = strobe_ff;
   assign rsp_start_client = out_client_ff;
   assign rsp_table_full   = full_ff;
   assign rsp_last         = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dstt_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;
         search_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         pend_ff   <= pend_in;
         search_ff <= search_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      client_ff      <= client_in;
      stamp_ff       <= stamp_in;
      pend_client_ff <= pend_client_in;
      out_client_ff  <= out_client_in;
      full_ff        <= full_in;
      last_ff        <= last_in;
   end

`ifndef SYNTH
   a_accept_sweep: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == dstt_pkg::ST_SWEEP))
      else $error("accepted item did not start a sweep");

   a_tail_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dstt_pkg::ST_SWEEP) && stat.tail |=> (state_ff == dstt_pkg::ST_FLUSH))
      else $error("sweep did not end in flush");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dstt_pkg::ST_SWEEP) |-> (count_ff <= dstt_pkg::COUNT_W'(dstt_pkg::MAX_RESULTS)))
      else $error("release count over the cap");

   a_full_last: assert property (@(posedge clock) disable iff (reset)
      strobe_in && full_in |-> last_in && (cmd_ff == dstt_pkg::CMD_ADD))
      else $error("full result not marked last");
`endif

endmodule

// ===== hw/rtl/delayed_start_timer_table.sv =====
// Top level: controller plus a chain of timer cells walked by a one-hot token.
//
// Command port: an item (req_cmd, req_client, req_delay_ms, req_now_ms) is taken
// at a clock edge with start high and busy low. Commands: tick releases every
// armed slot due at or before req_now_ms, lowest slot first; add arms the lowest
// free slot with now plus delay (saturated); cancel frees the lowest armed slot
// holding req_client; code 3 does nothing.
// Result port: rsp_strobe marks each result for one cycle; the receiver cannot
// stall it. A tick gives one result per released slot (at most 16), the final one
// with rsp_last. An add into a full table gives one result with rsp_table_full
// and rsp_last set. Other items give no result.
// Timing: after the accepting edge the token steps through one cell a cycle; busy
// stays high through the sweep and the flush, and no item is taken until busy falls.
// A release is held in pend_ff until the next release or the end of the sweep,
// and only then registered onto rsp_strobe; the last result, and a table-full
// result, shows in the first cycle with busy low.
// Reset: synchronous, active high; frees every slot and idles the controller.
module delayed_start_timer_table #(
   parameter int SLOTS = dstt_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dstt_pkg::CMD_W-1:0]      req_cmd,
   input  logic [dstt_pkg::CLIENT_W-1:0]   req_client,
   input  logic [dstt_pkg::DELAY_W-1:0]    req_delay_ms,
   input  logic [dstt_pkg::TIME_W-1:0]     req_now_ms,
   output logic                            rsp_strobe,
   output logic [dstt_pkg::CLIENT_W-1:0]   rsp_start_client,
   output logic                            rsp_table_full,
   output logic                            rsp_last
);

   logic                            inject;
   dstt_pkg::cell_bus_type          bus;
   dstt_pkg::chain_stat_type        stat;
   logic [SLOTS-1:0]                token;
   logic [SLOTS-1:0]                hit;
   logic [dstt_pkg::CLIENT_W-1:0]   hit_client [SLOTS];
   logic [dstt_pkg::CLIENT_W-1:0]   sel_client;

   dstt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_client       (req_client),
      .req_delay_ms     (req_delay_ms),
      .req_now_ms       (req_now_ms),
      .inject           (inject),
      .bus              (bus),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_start_client (rsp_start_client),
      .rsp_table_full   (rsp_table_full),
      .rsp_last         (rsp_last)
   );

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic tok_in;
      if (i == 0) begin : g_head
         assign tok_in = inject;
      end else begin : g_link
         assign tok_in = token[i-1];
      end
      dstt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .token_in   (tok_in),
         .token_out  (token[i]),
         .bus        (bus),
         .hit        (hit[i]),
         .hit_client (hit_client[i])
      );
   end

   // Only the cell holding the token can hit, so an OR picks its client.
   always_comb begin
      sel_client = '0;
      for (int i = 0; i < SLOTS; i++) begin
         sel_client = sel_client | (hit_client[i] & {dstt_pkg::CLIENT_W{hit[i]}});
      end
   end

   assign stat.hit    = |hit;
   assign stat.client = sel_client;
   assign stat.tail   = token[SLOTS-1];

`ifndef SYNTH
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token))
      else $error("more than one cell holds the token");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (token == '0))
      else $error("token in the chain while idle");

   a_hit_with_token: assert property (@(posedge clock) disable iff (reset)
      (hit & ~token) == '0)
      else $error("cell acted without the token");
`endif

endmodule
